FILE: hdl/cse_pkg.sv
// shared types and constants for the counting sort engine
package cse_pkg;

    localparam int KEY_W = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef logic [1:0] t_rd_sel;

    localparam t_rd_sel RD_KEY      = 2'd0;
    localparam t_rd_sel RD_PTR      = 2'd1;
    localparam t_rd_sel RD_PTR_NEXT = 2'd2;

    typedef struct packed {
        logic    clr_wr;
        logic    key_cap;
        logic    ins_wr;
        logic    pop_wr;
        logic    ptr_inc;
        logic    out_load;
        logic    out_empty;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic total_zero;
        logic full;
        logic in_range;
        logic rdata_zero;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/counting_sort_engine_core.sv
// insert: bin read, then write back; a dropped insert is not stored
// pop: read bin, skip empty bins with the scan pointer, decrement, load result;
// an empty pop loads an empty result; one transaction at a time, set by the
// single read-modify-write ram port; the result register holds a pop result
// while the next transaction is taken; reset: synchronous active low, then a
// clearing pass zeroes the bin ram, with input stall high throughout
module counting_sort_engine_core import cse_pkg::*; #(
    parameter int KEY_RANGE = 128,
    parameter int MAX_ITEMS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_op,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [KEY_W-1:0] o_sorted_key,
    output logic             o_empty_res,
    output logic             o_last
);

    t_cmd cmd;
    t_sts sts;

    cse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cse_dpath #(
        .KEY_RANGE (KEY_RANGE),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_key        (i_key),
        .i_out_stall  (i_stall),
        .o_valid      (o_valid),
        .o_sorted_key (o_sorted_key),
        .o_empty_res  (o_empty_res),
        .o_last       (o_last)
    );

endmodule

FILE: hdl/cse_ram.sv
// generic single write port ram with registered read
module cse_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cse_dpath.sv
// datapath: bin count ram, scan pointer, item total, clear counter and result register
module cse_dpath import cse_pkg::*; #(
    parameter int KEY_RANGE = 128,
    parameter int MAX_ITEMS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_out_stall,
    output logic             o_valid,
    output logic [KEY_W-1:0] o_sorted_key,
    output logic             o_empty_res,
    output logic             o_last
);

    localparam int AW = $clog2(KEY_RANGE);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_key;
    logic [AW-1:0]    r_clr;
    logic [CW-1:0]    r_total, n_total;
    logic             r_out_valid;
    logic [KEY_W-1:0] r_sorted_key;
    logic             r_empty;
    logic             r_last;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [CW-1:0]    ram_rdata;
    logic [AW-1:0]    key_idx;

    assign key_idx = AW'(i_key);

    cse_ram #(
        .WIDTH (CW),
        .DEPTH (KEY_RANGE)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (i_cmd.rd_sel)
            RD_KEY:      ram_raddr = key_idx;
            RD_PTR:      ram_raddr = r_ptr;
            RD_PTR_NEXT: ram_raddr = r_ptr + AW'(1);
            default:     ram_raddr = r_ptr;
        endcase
    end

    always_comb begin
        ram_we    = i_cmd.clr_wr | i_cmd.ins_wr | i_cmd.pop_wr;
        ram_waddr = r_ptr;
        ram_wdata = ram_rdata - CW'(1);
        if (i_cmd.clr_wr) begin
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (i_cmd.ins_wr) begin
            ram_waddr = r_key;
            ram_wdata = ram_rdata + CW'(1);
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ins_wr && (r_key < r_ptr)) begin
            n_ptr = r_key;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + AW'(1);
        end
        n_total = r_total;
        if (i_cmd.ins_wr) begin
            n_total = r_total + CW'(1);
        end else if (i_cmd.pop_wr) begin
            n_total = r_total - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_total     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr   <= n_ptr;
            r_total <= n_total;
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_cap) begin
            r_key <= key_idx;
        end
        if (i_cmd.out_load) begin
            r_sorted_key <= i_cmd.out_empty ? '0 : KEY_W'(r_ptr);
            r_empty      <= i_cmd.out_empty;
            r_last       <= ~i_cmd.out_empty & (r_total == '0);
        end
    end

    always_comb begin
        o_sts.total_zero = (r_total == '0);
        o_sts.full       = (r_total == CW'(MAX_ITEMS));
        o_sts.in_range   = (32'(i_key) < 32'(KEY_RANGE));
        o_sts.rdata_zero = (ram_rdata == '0);
        o_sts.clr_last   = (r_clr == AW'(KEY_RANGE - 1));
        o_sts.out_free   = ~r_out_valid | ~i_out_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_sorted_key = r_sorted_key;
    assign o_empty_res  = r_empty;
    assign o_last       = r_last;

endmodule

FILE: hdl/cse_ctrl.sv
// controller state machine: clear pass, insert read-modify-write, pop scan
module cse_ctrl import cse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_empty, n_empty;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        n_state = r_state;
        n_empty = r_empty;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_PTR;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_INSERT) begin
                        if (i_sts.in_range && !i_sts.full) begin
                            o_cmd.key_cap = 1'b1;
                            o_cmd.rd_sel  = RD_KEY;
                            n_state       = S_INS;
                        end
                    end else if (i_sts.total_zero) begin
                        n_empty = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_empty = 1'b0;
                        n_state = S_CHK;
                    end
                end
            end
            S_INS: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_CHK: begin
                if (i_sts.rdata_zero) begin
                    o_cmd.ptr_inc = 1'b1;
                    o_cmd.rd_sel  = RD_PTR_NEXT;
                end else begin
                    o_cmd.pop_wr = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_empty = r_empty;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_empty <= n_empty;
        end
    end

endmodule

FILE: hdl/cse_checker.sv
// port level checks for the counting sort engine, bound to the top level
module cse_checker import cse_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_op,
    input logic [KEY_W-1:0] i_key,
    input logic             o_valid,
    input logic             i_stall,
    input logic [KEY_W-1:0] o_sorted_key,
    input logic             o_empty_res,
    input logic             o_last
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sorted_key)
            && $stable(o_empty_res) && $stable(o_last))
        else $error("result changed while stalled");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_op) && $stable(i_key))
        else $error("input changed while stalled");

    // empty result carries zero key and no last flag
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> (o_sorted_key == '0) && !o_last)
        else $error("empty result with key or last set");

    // clearing pass blocks input after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled after reset");

    // no result straight out of reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind counting_sort_engine_core cse_checker u_cse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_op         (i_op),
    .i_key        (i_key),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sorted_key (o_sorted_key),
    .o_empty_res  (o_empty_res),
    .o_last       (o_last)
);
